@@ design/cacc_pkg.sv @@
// Shared constants for the cellular-automaton attractor classifier.
// Field widths, verdict codes and register reset values; no dependencies.
package cacc_pkg;

    localparam int RULE_W   = 32;
    localparam int CELL_W   = 4;
    localparam int VERDICT_W = 2;
    localparam int COUNT_W  = 13;

    localparam logic [CELL_W-1:0]    CELL_RESET = 4'd8;
    localparam logic [COUNT_W-1:0]   TALLY_MAX  = 13'h1FFF;

    localparam logic [VERDICT_W-1:0] VERDICT_FIXED = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_MULTI = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_NONE  = 2'd2;

endpackage

@@ design/ca_rule_cycle_classifier_unit.sv @@
// Automaton attractor classifier top level; uses cacc_pkg and cacc_successor.
// Sequence: ST_CLEAR sweeps the map; per start state ST_START_RD and ST_START_WR
// read and mark it, then each trajectory step is ST_STEP_RD then ST_STEP_EVAL.
// Throughput: one rule at a time; each step is a read and a write-back on the map
// port, and ST_DONE holds the result until the output register is free.
// Reset: control, cell count (to 8) and result valid cleared; the map is swept per rule.
module ca_rule_cycle_classifier_unit import cacc_pkg::*; #(
    parameter int MAX_CELLS = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CELL_W-1:0]    cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,    // rule_word
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata     // verdict, fixed_point_count, zero pad
);

    localparam int AW = MAX_CELLS;
    localparam int SW = MAX_CELLS + 1;
    localparam int DW = SW + 1;
    localparam int NW = $clog2(MAX_CELLS + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_START_RD, ST_START_WR, ST_STEP_RD, ST_STEP_EVAL, ST_DONE
    } state_t;

    state_t               state_reg;
    logic [CELL_W-1:0]    cell_count_reg;
    logic [RULE_W-1:0]    rule_reg;
    logic [NW-1:0]        n_reg;
    logic [SW-1:0]        states_reg;
    logic [SW-1:0]        idx_reg;
    logic [AW-1:0]        cur_reg;
    logic [AW-1:0]        nxt_reg;
    logic [COUNT_W-1:0]   tally_reg;
    logic [VERDICT_W-1:0] res_verdict_reg;
    logic [COUNT_W-1:0]   res_count_reg;
    logic                 m_tvalid_reg;
    logic [VERDICT_W-1:0] m_verdict_reg;
    logic [COUNT_W-1:0]   m_count_reg;

    logic [DW-1:0]        mem [0:(1<<AW)-1];
    logic [DW-1:0]        rdata_reg;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 we;
    logic [AW-1:0]        wr_addr;
    logic [DW-1:0]        wr_data;

    logic [NW-1:0]        n_eff;
    logic [SW-1:0]        idx_inc;
    logic [SW-1:0]        tag;
    logic                 last_idx;
    logic                 rd_counted;
    logic [SW-1:0]        rd_tag;
    logic [AW-1:0]        nxt_state;
    logic                 is_fixed;

    cacc_successor #(.MAX_CELLS(MAX_CELLS)) u_succ (
        .rule      (rule_reg),
        .cells     (n_reg),
        .cur_state (cur_reg),
        .nxt_state (nxt_state)
    );

    assign n_eff      = (32'(cell_count_reg) > MAX_CELLS) ? NW'(MAX_CELLS) : NW'(cell_count_reg);
    assign idx_inc    = idx_reg + 1'b1;
    assign tag        = idx_inc;
    assign last_idx   = (idx_inc == states_reg);
    assign rd_counted = rdata_reg[DW-1];
    assign rd_tag     = rdata_reg[SW-1:0];
    assign is_fixed   = (nxt_reg == cur_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_verdict_reg};

    // map port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        we      = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                we      = 1'b1;
                wr_addr = idx_reg[AW-1:0];
            end
            ST_START_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[AW-1:0];
            end
            ST_START_WR: begin
                we      = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                wr_data = {rd_counted, tag};
            end
            ST_STEP_RD: begin
                rd_en   = 1'b1;
                rd_addr = nxt_state;
            end
            ST_STEP_EVAL: begin
                if (is_fixed) begin
                    we      = !rd_counted;
                    wr_addr = cur_reg;
                    wr_data = {1'b1, tag};
                end else if (rd_tag != tag) begin
                    we      = 1'b1;
                    wr_addr = nxt_reg;
                    wr_data = {rd_counted, tag};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cell_count_reg <= CELL_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cell_count_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        rule_reg   <= s_tdata;
                        n_reg      <= n_eff;
                        states_reg <= SW'(1) << n_eff;
                        idx_reg    <= '0;
                        tally_reg  <= '0;
                        state_reg  <= ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    if (last_idx) begin
                        idx_reg   <= '0;
                        state_reg <= ST_START_RD;
                    end else begin
                        idx_reg <= idx_inc;
                    end
                end
                ST_START_RD: begin
                    state_reg <= ST_START_WR;
                end
                ST_START_WR: begin
                    cur_reg   <= idx_reg[AW-1:0];
                    state_reg <= ST_STEP_RD;
                end
                ST_STEP_RD: begin
                    nxt_reg   <= nxt_state;
                    state_reg <= ST_STEP_EVAL;
                end
                ST_STEP_EVAL: begin
                    if (is_fixed) begin
                        logic [COUNT_W-1:0] tally_new;
                        tally_new = tally_reg;
                        if (!rd_counted && tally_reg != TALLY_MAX) begin
                            tally_new = tally_reg + 1'b1;
                        end
                        tally_reg <= tally_new;
                        if (last_idx) begin
                            if (tally_new != '0) begin
                                res_verdict_reg <= VERDICT_FIXED;
                                res_count_reg   <= tally_new;
                            end else begin
                                res_verdict_reg <= VERDICT_NONE;
                                res_count_reg   <= '0;
                            end
                            state_reg <= ST_DONE;
                        end else begin
                            idx_reg   <= idx_inc;
                            state_reg <= ST_START_RD;
                        end
                    end else if (rd_tag == tag) begin
                        res_verdict_reg <= VERDICT_MULTI;
                        res_count_reg   <= '0;
                        state_reg       <= ST_DONE;
                    end else begin
                        cur_reg   <= nxt_reg;
                        state_reg <= ST_STEP_RD;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg  <= 1'b1;
                        m_verdict_reg <= res_verdict_reg;
                        m_count_reg   <= res_count_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a fixed point's own entry must already carry this walk's mark
    a_fixed_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP_EVAL && is_fixed) |-> (rd_tag == tag))
        else $error("fixed point entry not marked by current walk");

    a_multi_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_verdict_reg == VERDICT_MULTI) |-> (m_count_reg == '0))
        else $error("multi-length cycle beat carries a count");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && state_reg == ST_CLEAR))
        else $error("input taken without starting the clearing sweep");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_START_RD) |-> (idx_reg < states_reg))
        else $error("start index beyond state space");
`endif

endmodule

@@ design/cacc_successor.sv @@
// Next-state logic of the five-neighbourhood automaton, null boundaries.
// Depends on cacc_pkg for the rule width.
module cacc_successor import cacc_pkg::*; #(
    parameter int MAX_CELLS = 12
) (
    input  logic [RULE_W-1:0]                  rule,
    input  logic [$clog2(MAX_CELLS+1)-1:0]     cells,
    input  logic [MAX_CELLS-1:0]               cur_state,
    output logic [MAX_CELLS-1:0]               nxt_state
);

    localparam int NW = $clog2(MAX_CELLS + 1);

    logic [MAX_CELLS+3:0] ext;

    assign ext = {2'b00, cur_state, 2'b00};

    for (genvar b = 0; b < MAX_CELLS; b++) begin : g_cell
        logic [4:0] code;
        assign code = ext[b +: 5];
        assign nxt_state[b] = (NW'(b) < cells) ? rule[code] : 1'b0;
    end

endmodule

@@ tb/ca_rule_cycle_classifier_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for ca_rule_cycle_classifier_unit: directed and random rules are
// checked against an attractor predictor held in the bench. Depends on cacc_pkg and the design.
module ca_rule_cycle_classifier_unit_tb;
    import cacc_pkg::*;

    localparam int CELLS_MAX    = 12;
    localparam int STATE_SPAN   = 1 << CELLS_MAX;
    localparam int DRAIN_CYCLES = 64;
    localparam int GAP_MAX      = 13;
    localparam int LONG_HOLD    = 2000;
    localparam int TIMEOUT_NS   = 1_000_000_000;

    localparam logic [RULE_W-1:0] RULE_ZERO        = 32'h0000_0000;
    localparam logic [RULE_W-1:0] RULE_ONES        = 32'hFFFF_FFFF;
    localparam logic [RULE_W-1:0] RULE_KEEP        = 32'hF0F0_F0F0;
    localparam logic [RULE_W-1:0] RULE_INVERT      = 32'h0F0F_0F0F;
    localparam logic [RULE_W-1:0] RULE_FROM_LEFT1  = 32'hFF00_FF00;
    localparam logic [RULE_W-1:0] RULE_FROM_LEFT2  = 32'hFFFF_0000;
    localparam logic [RULE_W-1:0] RULE_FROM_RIGHT2 = 32'hAAAA_AAAA;
    localparam logic [RULE_W-1:0] RULE_CODE0_ONLY  = 32'h0000_0001;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [COUNT_W-1:0]   fixed_points;
    } verdict_t;

    typedef struct {
        logic [RULE_W-1:0] rule;
        verdict_t          want;
    } pending_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CELL_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;     // rule_word
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;          // verdict, fixed_point_count, zero pad

    pending_t             pending_verdicts[$];
    int                   walk_stamp[STATE_SPAN];
    bit                   fp_counted[STATE_SPAN];
    int                   walk_tag = 0;
    logic [CELL_W-1:0]    cells_now = CELL_RESET;
    int                   mismatch_count = 0;
    bit                   no_idle = 1'b0;
    int                   hold_off_cycles = 0;

    ca_rule_cycle_classifier_unit #(
        .MAX_CELLS (CELLS_MAX)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic int next_state(input logic [RULE_W-1:0] rule, input int s, input int n);
        int ext;
        int nxt;
        ext = s << 2;
        nxt = 0;
        for (int b = 0; b < n; b++) begin
            nxt |= int'(rule[(ext >> b) & 31]) << b;
        end
        return nxt;
    endfunction

    // walk_stamp tags each walk, standing in for a visited map cleared per walk
    function automatic verdict_t classify_rule(input logic [RULE_W-1:0] rule,
                                               input logic [CELL_W-1:0] cells);
        int       n;
        int       states;
        int       cur;
        int       nxt;
        bit       settled;
        verdict_t res;
        n = (cells > CELLS_MAX) ? CELLS_MAX : int'(cells);
        states = 1 << n;
        res.verdict = VERDICT_FIXED;
        res.fixed_points = '0;
        for (int i = 0; i < states; i++) begin
            fp_counted[i] = 1'b0;
        end
        for (int s = 0; s < states; s++) begin
            walk_tag++;
            cur = s;
            walk_stamp[cur] = walk_tag;
            nxt = next_state(rule, cur, n);
            settled = 1'b0;
            for (int j = 0; j < states && !settled; j++) begin
                if (walk_stamp[nxt] != walk_tag) begin
                    walk_stamp[nxt] = walk_tag;
                    cur = nxt;
                    nxt = next_state(rule, cur, n);
                end else if (nxt == cur) begin
                    if (!fp_counted[nxt]) begin
                        fp_counted[nxt] = 1'b1;
                        if (res.fixed_points != TALLY_MAX) begin
                            res.fixed_points++;
                        end
                    end
                    settled = 1'b1;
                end else begin
                    res.verdict = VERDICT_MULTI;
                    res.fixed_points = '0;
                    return res;
                end
            end
        end
        if (res.fixed_points == 0) begin
            res.verdict = VERDICT_NONE;
        end
        return res;
    endfunction

    // half fully random, half near-structured rules so fixed-point tallies get exercised
    function automatic logic [RULE_W-1:0] draw_rule();
        logic [RULE_W-1:0] base;
        logic [RULE_W-1:0] flips;
        if ($urandom_range(0, 1) == 0) begin
            return $urandom;
        end
        case ($urandom_range(0, 3))
            0: base = RULE_KEEP;
            1: base = RULE_ZERO;
            2: base = RULE_FROM_LEFT1;
            default: base = RULE_ONES;
        endcase
        flips = $urandom & $urandom & $urandom;
        return base ^ flips;
    endfunction

    task automatic flag_mismatch(input string text);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $realtime, text);
        end
    endtask

    task automatic send_rule(input logic [RULE_W-1:0] rule);
        int       gap;
        pending_t entry;
        gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rule;
        do @(posedge aclk); while (s_tready !== 1'b1);
        entry.rule = rule;
        entry.want = classify_rule(rule, cells_now);
        pending_verdicts.push_back(entry);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_cells(input logic [CELL_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cells_now = value;
    endtask

    task automatic test_reset_width();
        send_rule(RULE_ZERO);
        send_rule(RULE_ONES);
        send_rule(RULE_KEEP);
        send_rule(RULE_INVERT);
        drain_results();
    endtask

    task automatic test_tiny_automata();
        set_cells(4'd0);
        send_rule(RULE_ZERO);
        send_rule(RULE_ONES);
        send_rule($urandom);
        drain_results();
        set_cells(4'd1);
        send_rule(RULE_CODE0_ONLY);
        send_rule(RULE_INVERT);
        send_rule($urandom);
        drain_results();
    endtask

    // full width and the clamped settings above it
    task automatic test_widest();
        set_cells(4'd12);
        send_rule(RULE_ZERO);
        send_rule(RULE_KEEP);
        send_rule(RULE_FROM_LEFT1);
        send_rule(RULE_FROM_RIGHT2);
        send_rule(RULE_ONES);
        send_rule(RULE_INVERT);
        drain_results();
        set_cells(4'd13);
        send_rule(RULE_FROM_LEFT2);
        drain_results();
        set_cells(4'd15);
        send_rule(RULE_KEEP);
        send_rule(RULE_ZERO);
        drain_results();
    endtask

    task automatic test_random_rules();
        for (int phase = 0; phase < 5; phase++) begin
            set_cells(CELL_W'($urandom_range(1, 8)));
            no_idle = (phase == 2);
            repeat (20) send_rule(draw_rule());
            drain_results();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        set_cells(4'd3);
        no_idle = 1'b1;
        hold_off_cycles = LONG_HOLD;
        repeat (6) send_rule(draw_rule());
        drain_results();
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_width();
        test_tiny_automata();
        test_widest();
        test_random_rules();
        test_output_stall();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // result side: per-beat stall draw, long hold-off on request
    initial begin
        int                   stall;
        pending_t             head;
        logic [VERDICT_W-1:0] got_verdict;
        logic [COUNT_W-1:0]   got_points;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got_verdict = m_tdata[VERDICT_W-1:0];
            got_points  = m_tdata[VERDICT_W+COUNT_W-1:VERDICT_W];
            if (pending_verdicts.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat: verdict %0d count %0d",
                                        got_verdict, got_points));
            end else begin
                head = pending_verdicts.pop_front();
                if (got_verdict !== head.want.verdict ||
                    got_points !== head.want.fixed_points) begin
                    flag_mismatch($sformatf(
                        "rule %h: verdict exp %0d got %0d, count exp %0d got %0d",
                        head.rule, head.want.verdict, got_verdict,
                        head.want.fixed_points, got_points));
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
